// File: rtl/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared widths, register indexes, limits and types of the downmix resampler.
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MONO_W     = 17;
    localparam int IN_RATE_W  = 18;
    localparam int OUT_RATE_W = 16;
    localparam int CH_W       = 2;
    localparam int PHASE_W    = 18;
    localparam int PROD_W     = 34;
    localparam int MAG_W      = 32;
    localparam int DIVISOR_W  = OUT_RATE_W + 1;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [IN_RATE_W-1:0]  IN_RATE_MIN  = 18'd8000;
    localparam logic [IN_RATE_W-1:0]  IN_RATE_MAX  = 18'd192000;
    localparam logic [IN_RATE_W-1:0]  IN_RATE_RST  = 18'd48000;
    localparam logic [OUT_RATE_W-1:0] OUT_RATE_MIN = 16'd8000;
    localparam logic [OUT_RATE_W-1:0] OUT_RATE_MAX = 16'd48000;
    localparam logic [OUT_RATE_W-1:0] OUT_RATE_RST = 16'd16000;
    localparam logic [CH_W-1:0]       CH_RST       = 2'd2;
    localparam logic [CNT_W-1:0]      MAX_OUTPUTS  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE   = 2'd2;

    typedef struct packed {
        logic                     first;
        logic signed [MONO_W-1:0] cur;
    } t_entry;

    typedef struct packed {
        logic [IN_RATE_W-1:0]  step;
        logic [OUT_RATE_W-1:0] rate;
    } t_rates;

    function automatic logic [IN_RATE_W-1:0] clamp_in(input logic [IN_RATE_W-1:0] v);
        logic [IN_RATE_W-1:0] res;
        res = v;
        if (v < IN_RATE_MIN) res = IN_RATE_MIN;
        if (v > IN_RATE_MAX) res = IN_RATE_MAX;
        return res;
    endfunction

    function automatic logic [OUT_RATE_W-1:0] clamp_out(input logic [OUT_RATE_W-1:0] v);
        logic [OUT_RATE_W-1:0] res;
        res = v;
        if (v < OUT_RATE_MIN) res = OUT_RATE_MIN;
        if (v > OUT_RATE_MAX) res = OUT_RATE_MAX;
        return res;
    endfunction

endpackage

// File: rtl/dlr_front.sv
// ----------------------------------------------------------------------------
// dlr_front
// Accepts frames, downmixes them to mono half-sample units and tags the first.
// ----------------------------------------------------------------------------
module dlr_front
    import dlr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SAMPLE_W-1:0]   i_left,
    input  logic [SAMPLE_W-1:0]   i_right,
    input  logic                  i_stereo,
    input  logic                  i_full,
    output logic                  o_push,
    output t_entry                o_entry
);

    logic                     r_prev_valid;
    logic signed [MONO_W-1:0] w_left;
    logic signed [MONO_W-1:0] w_right;

    assign w_left  = MONO_W'($signed(i_left));
    assign w_right = MONO_W'($signed(i_right));

    assign o_ready = ~i_full;
    assign o_push  = i_valid & ~i_full;

    always_comb begin
        o_entry.first = ~r_prev_valid;
        if (i_stereo) begin
            o_entry.cur = w_left + w_right;
        end else begin
            o_entry.cur = {i_left, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
        end else if (o_push) begin
            r_prev_valid <= 1'b1;
        end
    end

endmodule

// File: rtl/dlr_fifo.sv
// ----------------------------------------------------------------------------
// dlr_fifo
// Short queue of mono requests between the front and the back.
// ----------------------------------------------------------------------------
module dlr_fifo
    import dlr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/dlr_div.sv
// ----------------------------------------------------------------------------
// dlr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlr_div
    import dlr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MAG_W-1:0]     i_dividend,
    input  logic [DIVISOR_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [MAG_W-1:0]     o_quot
);

    localparam int STEP_W = $clog2(MAG_W);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_cnt;
    logic [DIVISOR_W-1:0] r_div;
    logic [DIVISOR_W-1:0] r_rem;
    logic [MAG_W-1:0]     r_quo;
    logic [DIVISOR_W:0]   w_shift;
    logic                 w_ge;

    assign w_shift = {r_rem, r_quo[MAG_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign o_done  = r_done;
    assign o_quot  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= DIVISOR_W'(w_shift - {1'b0, r_div});
            end else begin
                r_rem <= w_shift[DIVISOR_W-1:0];
            end
            r_quo <= {r_quo[MAG_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/dlr_back.sv
// ----------------------------------------------------------------------------
// dlr_back
// Interpolation sequencer: phase walk, products, divide and output register.
// ----------------------------------------------------------------------------
module dlr_back
    import dlr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_rates              i_rates,
    input  logic                i_empty,
    input  t_entry              i_entry,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_sample,
    output logic                o_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                r_state;
    logic signed [MONO_W-1:0]  r_prev;
    logic signed [MONO_W-1:0]  r_cur;
    logic [PHASE_W-1:0]        r_phase;
    logic [CNT_W-1:0]          r_n;
    logic signed [PROD_W-1:0]  r_p0;
    logic signed [PROD_W-1:0]  r_p1;
    logic                      r_neg;
    logic                      r_run_last;
    logic [SAMPLE_W-1:0]       r_q;
    logic                      r_out_valid;
    logic [SAMPLE_W-1:0]       r_out_sample;
    logic                      r_out_last;

    logic [OUT_RATE_W-1:0]     w_diff;
    logic [PHASE_W:0]          w_next;
    logic signed [PROD_W-1:0]  w_p0;
    logic signed [PROD_W-1:0]  w_p1;
    logic signed [PROD_W-1:0]  w_acc;
    logic [PROD_W-1:0]         w_abs;
    logic                      w_start;
    logic                      w_done;
    logic [MAG_W-1:0]          w_quot;
    logic                      w_load;
    logic                      w_more;

    assign w_diff  = i_rates.rate - r_phase[OUT_RATE_W-1:0];
    assign w_next  = {1'b0, r_phase} + {1'b0, i_rates.step};
    assign w_p0    = $signed(r_prev) * $signed({1'b0, w_diff});
    assign w_p1    = $signed(r_cur) * $signed({1'b0, r_phase[OUT_RATE_W-1:0]});
    assign w_acc   = r_p0 + r_p1;
    assign w_abs   = w_acc[PROD_W-1] ? PROD_W'(-w_acc) : w_acc;
    assign w_start = (r_state == S_ADD);
    assign w_load  = (r_state == S_OUT) && (!r_out_valid || i_ready);
    assign w_more  = (r_phase < PHASE_W'(i_rates.rate)) && (r_n < MAX_OUTPUTS);
    assign o_pop   = (r_state == S_IDLE) && !i_empty;

    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;
    assign o_last   = r_out_last;

    dlr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_abs[MAG_W-1:0]),
        .i_divisor  ({i_rates.rate, 1'b0}),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_p0       <= w_p0;
            r_p1       <= w_p1;
            r_run_last <= (w_next >= (PHASE_W+1)'(i_rates.rate))
                          || (r_n == CNT_W'(MAX_OUTPUTS - 3'd1));
        end
        if (r_state == S_ADD) begin
            r_neg <= w_acc[PROD_W-1];
        end
        if (r_state == S_DIV && w_done) begin
            r_q <= r_neg ? SAMPLE_W'(-w_quot[SAMPLE_W-1:0]) : w_quot[SAMPLE_W-1:0];
        end
        if (w_load) begin
            r_out_sample <= r_q;
            r_out_last   <= r_run_last;
        end
        if (o_pop) begin
            r_cur <= i_entry.cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_phase     <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_n <= '0;
                        if (i_entry.first) begin
                            r_prev <= i_entry.cur;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (w_more) begin
                        r_state <= S_MUL;
                    end else begin
                        if (r_phase >= PHASE_W'(i_rates.rate)) begin
                            r_phase <= r_phase - PHASE_W'(i_rates.rate);
                        end else begin
                            r_phase <= '0;
                        end
                        r_prev  <= r_cur;
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_phase <= w_next[PHASE_W-1:0];
                        r_n     <= r_n + 1'b1;
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/downmix_linear_resampler_top.sv
// ----------------------------------------------------------------------------
// downmix_linear_resampler_top
// Mono downmix and linear-interpolation sample rate converter.
// ----------------------------------------------------------------------------
// Each accepted frame is downmixed to mono and queued. The back end uses the
// 32-step restoring divider that forms each interpolated value; a frame
// produces up to six samples. The very first frame after reset only primes the
// history. Input frames keep being accepted while the queue has room, and a
// finished sample waits in the output register while the next one is computed.
module downmix_linear_resampler_top
    import dlr_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [31:0]           i_s_axis_tdata,  // sample_left[15:0], sample_right[31:16]
    input  logic                  i_s_axis_tlast,  // frame_last
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [15:0]           o_m_axis_tdata,  // out_sample[15:0]
    output logic                  o_m_axis_tlast   // run_last
);

    logic [IN_RATE_W-1:0]  r_input_rate;
    logic [CH_W-1:0]       r_channel_count;
    logic [OUT_RATE_W-1:0] r_output_rate;

    t_rates w_rates;
    t_entry w_push_entry;
    t_entry w_pop_entry;
    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;
    logic   w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_rate    <= IN_RATE_RST;
            r_channel_count <= CH_RST;
            r_output_rate   <= OUT_RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INPUT_RATE:    r_input_rate    <= i_cfg_wdata;
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_wdata[CH_W-1:0];
                CFG_OUTPUT_RATE:   r_output_rate   <= i_cfg_wdata[OUT_RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_rates.step    = clamp_in(r_input_rate);
    assign w_rates.rate    = clamp_out(r_output_rate);
    assign o_s_axis_tready = w_ready & i_rst_n;

    dlr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid & i_rst_n),
        .o_ready  (w_ready),
        .i_left   (i_s_axis_tdata[15:0]),
        .i_right  (i_s_axis_tdata[31:16]),
        .i_stereo (r_channel_count[1]),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    dlr_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_entry (w_pop_entry)
    );

    dlr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rates  (w_rates),
        .i_empty  (w_empty),
        .i_entry  (w_pop_entry),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_sample (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast)
    );

endmodule

// File: rtl/dlr_checker.sv
// ----------------------------------------------------------------------------
// dlr_checker
// Port-level checks of the resampler top level, bound to every instance.
// ----------------------------------------------------------------------------
module dlr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_idx,
    input logic [17:0] i_cfg_wdata,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output request present right after reset");

    a_in_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rst_n || o_s_axis_tready)
        else $error("input not ready right after reset");

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output request dropped while stalled");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output request changed while stalled");

endmodule

bind downmix_linear_resampler_top dlr_checker u_dlr_checker (.*);
